// File: hw/rtl/dfpf_pkg.sv
// ----------------------------------------------------------------------------
// dfpf_pkg: shared types and constants for the decimal formatter
// Holds the decimal weights, ASCII codes, widths and the control struct
// that the sequencer sends to the digit unit.
// ----------------------------------------------------------------------------
package dfpf_pkg;

   localparam int VALUE_W   = 16;
   localparam int MAG_W     = 16;
   localparam int DIGIT_W   = 4;
   localparam int CHAR_W    = 7;
   localparam int PLACES_W  = 3;
   localparam int POS_W     = 3;
   localparam int ZI_W      = 2;

   // Last digit position handled by the shared unit (weight of ten)
   localparam logic [ZI_W-1:0] ZI_LAST = 2'd3;

   // Reset value and upper bound of the decimal places register
   localparam logic [PLACES_W-1:0] PLACES_RESET = 3'd1;
   localparam logic [PLACES_W-1:0] PLACES_MAX   = 3'd4;

   // Point position that means "point just before the units digit"
   localparam logic [POS_W-1:0] POS_BEFORE_UNITS = 3'd4;
   localparam logic [POS_W-1:0] POS_NONE         = 3'd5;

   localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'h30;
   localparam logic [CHAR_W-1:0] ASCII_POINT = 7'h2E;
   localparam logic [CHAR_W-1:0] ASCII_MINUS = 7'h2D;

   // Control from the sequencer to the digit unit
   typedef struct packed {
      logic load;   // take a new magnitude, clear the digit count
      logic step;   // one compare-and-subtract of the current weight
      logic clear;  // digit finished, clear the count
   } unit_ctrl_type;

   // Decimal weight of each leading digit position
   function automatic logic [MAG_W-1:0] weight_of(input logic [ZI_W-1:0] zi);
      logic [MAG_W-1:0] w;
      unique case (zi)
         2'd0:    w = 16'd10000;
         2'd1:    w = 16'd1000;
         2'd2:    w = 16'd100;
         default: w = 16'd10;
      endcase
      return w;
   endfunction

endpackage

// File: hw/rtl/dfpf_digit_unit.sv
// ----------------------------------------------------------------------------
// dfpf_digit_unit: shared compare-and-subtract unit
// Holds the running magnitude and counts how often the selected decimal
// weight could be taken off it; that count is the current digit.
// ----------------------------------------------------------------------------
module dfpf_digit_unit (
   input  logic                              clock,
   input  dfpf_pkg::unit_ctrl_type           ctrl,
   input  logic [dfpf_pkg::MAG_W-1:0]        load_mag,
   input  logic [dfpf_pkg::ZI_W-1:0]         zi,
   output logic [dfpf_pkg::MAG_W-1:0]        mag,
   output logic [dfpf_pkg::DIGIT_W-1:0]      digit,
   output logic                              below
);

   logic [dfpf_pkg::MAG_W-1:0]   mag_ff;
   logic [dfpf_pkg::MAG_W-1:0]   mag_in;
   logic [dfpf_pkg::DIGIT_W-1:0] digit_ff;
   logic [dfpf_pkg::DIGIT_W-1:0] digit_in;
   logic [dfpf_pkg::MAG_W-1:0]   weight;

   // One compare and one subtract against the selected weight
   assign weight = dfpf_pkg::weight_of(zi);
   assign below  = (mag_ff < weight);

   always_comb begin
      mag_in   = mag_ff;
      digit_in = digit_ff;
      if (ctrl.load) begin
         mag_in   = load_mag;
         digit_in = '0;
      end else begin
         if (ctrl.step && !below) begin
            mag_in   = mag_ff - weight;
            digit_in = digit_ff + 4'd1;
         end
         if (ctrl.clear) begin
            digit_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      mag_ff   <= mag_in;
      digit_ff <= digit_in;
   end

   assign mag   = mag_ff;
   assign digit = digit_ff;

endmodule

// File: hw/rtl/decimal_fixed_point_formatter.sv
// ----------------------------------------------------------------------------
// decimal_fixed_point_formatter: signed 16-bit value to decimal ASCII text
// Emits one character per rsp transaction, most significant first, with
// rsp_last on the final one; optional fixed decimal point from the CSR.
// ----------------------------------------------------------------------------
// One value is taken at a time; req_ready is high only while the block is
// idle. The digit loop uses a single compare-and-subtract unit that
// removes one decimal weight per cycle, so the time for each leading
// digit grows with its value; a stalled rsp side holds the sequencer in
// its character states. decimal_places is written through
// csr_write_enable/csr_write_data and must only change while
// no value is in flight; values above 4 act as 4.
module decimal_fixed_point_formatter (
   input  logic                                   clock,
   input  logic                                   reset,
   // configuration
   input  logic                                   csr_write_enable,
   input  logic [dfpf_pkg::PLACES_W-1:0]          csr_write_data,
   // input channel
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [dfpf_pkg::VALUE_W-1:0]    req_value,
   // result channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [dfpf_pkg::CHAR_W-1:0]            rsp_character,
   output logic                                   rsp_last
);

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_SIGN  = 8'b0000_0010,
      ST_DIV   = 8'b0000_0100,
      ST_LEAD  = 8'b0000_1000,
      ST_POINT = 8'b0001_0000,
      ST_DIGIT = 8'b0010_0000,
      ST_TAIL  = 8'b0100_0000,
      ST_UNIT  = 8'b1000_0000
   } state_type;

   state_type                            state_ff, state_in;
   logic [dfpf_pkg::ZI_W-1:0]            zi_ff, zi_in;
   logic                                 started_ff, started_in;
   logic [dfpf_pkg::POS_W-1:0]           point_pos_ff, point_pos_in;
   logic [dfpf_pkg::PLACES_W-1:0]        places_ff;

   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [dfpf_pkg::CHAR_W-1:0]          rsp_character_ff, rsp_character_in;
   logic                                 rsp_last_ff, rsp_last_in;

   dfpf_pkg::unit_ctrl_type              ctrl;
   logic [dfpf_pkg::MAG_W-1:0]           load_mag;
   logic [dfpf_pkg::MAG_W-1:0]           mag;
   logic [dfpf_pkg::DIGIT_W-1:0]         digit;
   logic                                 below;

   logic                                 out_free;
   logic                                 push;
   logic [dfpf_pkg::CHAR_W-1:0]          push_char;
   logic                                 push_last;
   logic                                 advance;
   logic [dfpf_pkg::PLACES_W-1:0]        places_clamped;
   logic                                 at_point;

   // Decimal places register
   always_ff @(posedge clock) begin
      if (reset) begin
         places_ff <= dfpf_pkg::PLACES_RESET;
      end else if (csr_write_enable) begin
         places_ff <= csr_write_data;
      end
   end

   // Point position: 5 means none, 4 means just before the units digit
   assign places_clamped = (places_ff > dfpf_pkg::PLACES_MAX) ? dfpf_pkg::PLACES_MAX
                                                             : places_ff;

   // Magnitude of the input; -32768 wraps to 0x8000, which is 32768
   assign load_mag = req_value[dfpf_pkg::VALUE_W-1] ? (~req_value + 16'd1) : req_value;

   assign req_ready = (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign at_point  = ({1'b0, zi_ff} == point_pos_ff);

   dfpf_digit_unit u_digit_unit (
      .clock    (clock),
      .ctrl     (ctrl),
      .load_mag (load_mag),
      .zi       (zi_ff),
      .mag      (mag),
      .digit    (digit),
      .below    (below)
   );

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      zi_in        = zi_ff;
      started_in   = started_ff;
      point_pos_in = point_pos_ff;
      ctrl         = '0;
      push         = 1'b0;
      push_char    = dfpf_pkg::ASCII_ZERO;
      push_last    = 1'b0;
      advance      = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ctrl.load    = 1'b1;
               zi_in        = '0;
               started_in   = 1'b0;
               point_pos_in = dfpf_pkg::POS_NONE - places_clamped;
               if (req_value == '0) begin
                  state_in = ST_UNIT;
               end else if (req_value[dfpf_pkg::VALUE_W-1]) begin
                  state_in = ST_SIGN;
               end else begin
                  state_in = ST_DIV;
               end
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               push      = 1'b1;
               push_char = dfpf_pkg::ASCII_MINUS;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            ctrl.step = 1'b1;
            if (below) begin
               if (at_point) begin
                  state_in = started_ff ? ST_POINT : ST_LEAD;
               end else begin
                  state_in = ST_DIGIT;
               end
            end
         end
         ST_LEAD: begin
            if (out_free) begin
               push       = 1'b1;
               push_char  = dfpf_pkg::ASCII_ZERO;
               started_in = 1'b1;
               state_in   = ST_POINT;
            end
         end
         ST_POINT: begin
            if (out_free) begin
               push       = 1'b1;
               push_char  = dfpf_pkg::ASCII_POINT;
               started_in = 1'b1;
               state_in   = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            // leading zeros are dropped
            if (digit != '0 || started_ff) begin
               if (out_free) begin
                  push       = 1'b1;
                  push_char  = dfpf_pkg::ASCII_ZERO + {3'b000, digit};
                  started_in = 1'b1;
                  advance    = 1'b1;
               end
            end else begin
               advance = 1'b1;
            end
         end
         ST_TAIL: begin
            if (out_free) begin
               push      = 1'b1;
               push_char = dfpf_pkg::ASCII_POINT;
               state_in  = ST_UNIT;
            end
         end
         ST_UNIT: begin
            if (out_free) begin
               push      = 1'b1;
               push_char = dfpf_pkg::ASCII_ZERO + {3'b000, mag[dfpf_pkg::DIGIT_W-1:0]};
               push_last = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Move on to the next digit position, or to the units digit (via the point if it sits just before the units)
      if (advance) begin
         ctrl.clear = 1'b1;
         if (zi_ff == dfpf_pkg::ZI_LAST) begin
            state_in = (point_pos_ff == dfpf_pkg::POS_BEFORE_UNITS) ? ST_TAIL : ST_UNIT;
         end else begin
            zi_in    = zi_ff + 2'd1;
            state_in = ST_DIV;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      zi_ff        <= zi_in;
      started_ff   <= started_in;
      point_pos_ff <= point_pos_in;
   end

   // Output register
   always_comb begin
      rsp_valid_in     = rsp_valid_ff;
      rsp_character_in = rsp_character_ff;
      rsp_last_in      = rsp_last_ff;
      if (push) begin
         rsp_valid_in     = 1'b1;
         rsp_character_in = push_char;
         rsp_last_in      = push_last;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_character_ff <= rsp_character_in;
      rsp_last_ff      <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_character_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

// File: dv/decimal_fixed_point_formatter_checker.sv
// ----------------------------------------------------------------------------
// decimal_fixed_point_formatter_checker: result predictor and scoreboard
// Watches the csr, req and rsp ports of the formatter, keeps its own copy
// of the decimal places register, works out the text of every accepted
// value and compares each rsp transaction with the oldest expected one.
// ----------------------------------------------------------------------------
module decimal_fixed_point_formatter_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [dfpf_pkg::PLACES_W-1:0]       csr_write_data,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic signed [dfpf_pkg::VALUE_W-1:0] req_value,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic [dfpf_pkg::CHAR_W-1:0]         rsp_character,
   input  logic                                rsp_last,
   output int                                  pending_count,
   output int                                  fail_count
);

   typedef struct packed {
      logic [dfpf_pkg::CHAR_W-1:0] character;
      logic                        last;
   } text_char_type;

   logic [dfpf_pkg::PLACES_W-1:0] places_ff;
   text_char_type                 expected_text[$];

   initial fail_count = 0;

   // Build the characters one value should print and queue them
   task automatic predict_text(input logic [dfpf_pkg::VALUE_W-1:0] raw,
                               input logic [dfpf_pkg::PLACES_W-1:0] places_reg);
      logic [dfpf_pkg::CHAR_W-1:0] text [7];
      int                          len;
      int unsigned                 places;
      int unsigned                 point_at;
      int unsigned                 mag;
      int unsigned                 wgt;
      int unsigned                 digit;
      bit                          started;
      len     = 0;
      started = 1'b0;
      places  = (places_reg > dfpf_pkg::PLACES_MAX) ? dfpf_pkg::PLACES_MAX : places_reg;
      point_at = 5 - places;    // 5: no point, 4: point before the units digit
      if (raw == '0) begin
         text[0] = dfpf_pkg::ASCII_ZERO;
         len     = 1;
      end else begin
         if (raw[dfpf_pkg::VALUE_W-1]) begin
            text[len] = dfpf_pkg::ASCII_MINUS;
            len++;
            mag = 32'h1_0000 - raw;   // most negative value gives 32768
         end else begin
            mag = raw;
         end
         // ten-thousands down to tens, leading zeros dropped
         for (int zi = 0; zi < 4; zi++) begin
            if (zi == point_at) begin
               if (!started) begin
                  text[len] = dfpf_pkg::ASCII_ZERO;
                  len++;
               end
               text[len] = dfpf_pkg::ASCII_POINT;
               len++;
               started = 1'b1;
            end
            wgt   = 10 ** (4 - zi);
            digit = mag / wgt;
            if (digit != 0 || started) begin
               text[len] = dfpf_pkg::ASCII_ZERO + digit[dfpf_pkg::CHAR_W-1:0];
               len++;
               started = 1'b1;
            end
            mag = mag - digit * wgt;
         end
         // one place: point right before the units, no leading zero
         if (point_at == 4) begin
            text[len] = dfpf_pkg::ASCII_POINT;
            len++;
         end
         text[len] = dfpf_pkg::ASCII_ZERO + mag[dfpf_pkg::CHAR_W-1:0];
         len++;
      end
      for (int i = 0; i < len; i++)
         expected_text.push_back({text[i], (i == len - 1)});
   endtask

   // Track the register, check results, predict new values
   always @(posedge clock) begin
      text_char_type got;
      if (reset) begin
         places_ff <= dfpf_pkg::PLACES_RESET;
         expected_text.delete();
         pending_count <= 0;
      end else begin
         if (csr_write_enable)
            places_ff <= csr_write_data;
         if (rsp_valid && rsp_ready) begin
            if (expected_text.size() == 0) begin
               $error("unexpected rsp transaction: character %h last %b",
                      rsp_character, rsp_last);
               fail_count++;
            end else begin
               got = expected_text.pop_front();
               if (rsp_character !== got.character) begin
                  $error("character mismatch: expected %h, actual %h",
                         got.character, rsp_character);
                  fail_count++;
               end
               if (rsp_last !== got.last) begin
                  $error("last mismatch: expected %b, actual %b",
                         got.last, rsp_last);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready)
            predict_text(req_value, places_ff);
         pending_count <= expected_text.size();
      end
   end

endmodule

// File: dv/tb_decimal_fixed_point_formatter.sv
// ----------------------------------------------------------------------------
// tb_decimal_fixed_point_formatter: testbench top for the decimal formatter
// Drives directed and random values through the req channel under several
// decimal places settings, with random gaps and stalls on both channels,
// a long rsp hold-off and a drain pause; the checker scores every result.
// ----------------------------------------------------------------------------
module tb_decimal_fixed_point_formatter;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 60;
   localparam int PHASE_ITEMS  = 11;

   logic                                 clock            = 1'b0;
   logic                                 reset            = 1'b1;
   logic                                 csr_write_enable = 1'b0;
   logic [dfpf_pkg::PLACES_W-1:0]        csr_write_data   = '0;
   logic                                 req_valid        = 1'b0;
   logic                                 req_ready;
   logic signed [dfpf_pkg::VALUE_W-1:0]  req_value        = '0;
   logic                                 rsp_valid;
   logic                                 rsp_ready        = 1'b0;
   logic [dfpf_pkg::CHAR_W-1:0]          rsp_character;
   logic                                 rsp_last;

   int pending_count;
   int fail_count;
   int cycle_count;
   bit steady_mode   = 1'b0;   // no gaps on either side
   int hold_requests = 0;      // long receiver hold-offs asked for so far

   decimal_fixed_point_formatter u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_character    (rsp_character),
      .rsp_last         (rsp_last)
   );

   decimal_fixed_point_formatter_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_character    (rsp_character),
      .rsp_last         (rsp_last),
      .pending_count    (pending_count),
      .fail_count       (fail_count)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Gap length: mostly none or short, now and then long
   function automatic int pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Random value: raw random bits, or a short, edge or round magnitude with random sign
   function automatic logic signed [dfpf_pkg::VALUE_W-1:0] random_value();
      int unsigned                         pick;
      int unsigned                         mag;
      logic [31:0]                         bits;
      logic signed [dfpf_pkg::VALUE_W-1:0] v;
      pick = $urandom_range(0, 9);
      mag  = 0;
      bits = $urandom;
      v    = bits[dfpf_pkg::VALUE_W-1:0];
      case (pick)
         0, 1, 2, 3: mag = 0;
         4:       mag = $urandom_range(0, 9);
         5:       mag = $urandom_range(10, 99);
         6:       mag = $urandom_range(100, 999);
         7:       mag = $urandom_range(1000, 9999);
         8:       mag = $urandom_range(32758, 32768);
         default: mag = $urandom_range(1, 3) * 10 ** $urandom_range(1, 4);
      endcase
      if (pick > 3) begin
         v = mag[dfpf_pkg::VALUE_W-1:0];
         if ($urandom_range(0, 1)) v = -v;
      end
      return v;
   endfunction

   // One req transaction; returns at a falling edge after the gap
   task automatic send_value(input logic signed [dfpf_pkg::VALUE_W-1:0] v);
      int gap;
      req_valid <= 1'b1;
      req_value <= v;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      if (!steady_mode) begin
         gap = pick_gap();
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   endtask

   // Stop offering and wait until every expected character has arrived
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      @(negedge clock);
   endtask

   task automatic write_places(input logic [dfpf_pkg::PLACES_W-1:0] places);
      csr_write_enable <= 1'b1;
      csr_write_data   <= places;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Receiver: random stalls, long hold-off on request
   initial begin
      int gap;
      int held;
      int holds_done;
      holds_done = 0;
      @(negedge clock);
      forever begin
         if (holds_done < hold_requests) begin
            rsp_ready <= 1'b0;
            held = 0;
            while (held < HOLD_CYCLES) begin
               @(negedge clock);
               held++;
            end
            holds_done++;
         end else begin
            gap = steady_mode ? 0 : pick_gap();
            if (gap > 0) begin
               rsp_ready <= 1'b0;
               repeat (gap) @(negedge clock);
            end
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge clock);
         end
      end
   end

   // Run limit
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("status: fail");
      $finish;
   end

   // Stimulus
   initial begin
      logic [dfpf_pkg::PLACES_W-1:0] phase_places [8];
      phase_places = '{3'd2, 3'd3, 3'd5, 3'd7, 3'd6, 3'd0, 3'd4, 3'd1};
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed, reset setting of one place: short values print as .d
      send_value(16'sd0);
      send_value(16'sd5);
      send_value(-16'sd5);
      send_value(16'sd9);
      send_value(16'sd10);
      send_value(16'sd32767);
      send_value(-16'sd32768);
      send_value(-16'sd1);
      send_value(16'sd1);
      send_value(16'sd12345);
      wait_idle();

      // directed, most places: leading zero before the point
      write_places(dfpf_pkg::PLACES_MAX);
      send_value(16'sd5);
      send_value(-16'sd5);
      send_value(16'sd32767);
      send_value(-16'sd32768);
      send_value(16'sd0);
      wait_idle();

      // directed, no point
      write_places(3'd0);
      send_value(16'sd0);
      send_value(16'sd32767);
      send_value(-16'sd32768);
      send_value(16'sd100);
      send_value(-16'sd1);
      wait_idle();

      // random phases, one setting each
      for (int ph = 0; ph < 8; ph++) begin
         write_places(phase_places[ph]);
         steady_mode = (ph == 4);
         if (ph == 2)
            hold_requests++;   // receiver backs up, input stalls
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (ph == 5 && i == PHASE_ITEMS / 2)
               wait_idle();
            send_value(random_value());
         end
         wait_idle();
      end
      steady_mode = 1'b0;

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
